// ===== src/assert_macros.svh =====
// Assertion macros used by the stack bytecode executor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by another one on the next clock edge.
`define SBE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sbe_pkg.sv =====
// Types, opcodes, status codes and the ALU function of the bytecode executor.
`default_nettype none
package sbe_pkg;

  // Opcodes
  localparam logic [7:0] OP_PUSH      = 8'h41;
  localparam logic [7:0] OP_LOCAL_GET = 8'h20;
  localparam logic [7:0] OP_LOCAL_SET = 8'h21;
  localparam logic [7:0] OP_REG_LOAD  = 8'hF0;
  localparam logic [7:0] OP_REG_STORE = 8'hF1;
  localparam logic [7:0] OP_MEM       = 8'hF2;
  localparam logic [7:0] OP_ADD       = 8'h6A;
  localparam logic [7:0] OP_SUB       = 8'h6B;
  localparam logic [7:0] OP_AND       = 8'h71;
  localparam logic [7:0] OP_OR        = 8'h72;
  localparam logic [7:0] OP_XOR       = 8'h73;
  localparam logic [7:0] OP_SHL       = 8'h74;
  localparam logic [7:0] OP_SAR       = 8'h75;
  localparam logic [7:0] OP_SHR       = 8'h76;
  localparam logic [7:0] OP_END       = 8'h0B;
  localparam logic [7:0] OP_RETURN    = 8'h0F;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic [7:0] T_FLAG_IDX  = 8'd16;
  localparam logic [7:0] WIN_TAG_RST = 8'd12;

  // What the back end has to do for one byte
  typedef enum logic [2:0] {
    K_NONE,
    K_END,
    K_UNKNOWN,
    K_ALU,
    K_PUSH,
    K_GET,
    K_SET,
    K_MEM
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  opcode;
    logic [31:0] acc;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_FILL
  } bstate_t;

  function automatic logic [31:0] alu(input logic [7:0] op, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [4:0] s;
    logic [31:0] r;
    s = b[4:0];
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_SHL:  r = a << s;
      OP_SHR:  r = a >> s;
      default: r = $unsigned($signed(a) >>> s);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sbe_ifaces.sv =====
// Valid/ready channel interfaces for code bytes and results.
`default_nettype none
interface sbe_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface sbe_result_if #(parameter int DEPTH_W = 11);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               reg_written;
  logic [4:0]         reg_index;
  logic [31:0]        reg_value;
  logic [DEPTH_W-1:0] stack_depth;
  modport source (output valid, output status, output reg_written, output reg_index,
                  output reg_value, output stack_depth, input ready);
  modport sink (input valid, input status, input reg_written, input reg_index,
                input reg_value, input stack_depth, output ready);
endinterface
`default_nettype wire

// ===== src/sbe_front.sv =====
// Front end: collects operand bytes and classifies each byte into a work item.
`default_nettype none
module sbe_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sbe_code_if.sink           in_if,
  input  wire logic          q_full,
  input  wire logic          clr_busy,
  output logic               q_push,
  output sbe_pkg::item_t     q_item
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;

  assign in_if.ready = !q_full && !clr_busy;
  assign q_push      = in_if.valid && in_if.ready;

  // Decode of the current byte
  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    q_item.kind   = sbe_pkg::K_NONE;
    q_item.opcode = in_if.code_byte;
    q_item.acc    = 32'd0;
    if (phase_r == 3'd0) begin
      pend_nxt = in_if.code_byte;
      acc_nxt  = 32'd0;
      case (in_if.code_byte) inside
        sbe_pkg::OP_PUSH: phase_nxt = 3'd4;
        sbe_pkg::OP_LOCAL_GET, sbe_pkg::OP_LOCAL_SET,
        sbe_pkg::OP_REG_LOAD, sbe_pkg::OP_REG_STORE: phase_nxt = 3'd1;
        sbe_pkg::OP_MEM: phase_nxt = 3'd2;
        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_AND, sbe_pkg::OP_OR,
        sbe_pkg::OP_XOR, sbe_pkg::OP_SHL, sbe_pkg::OP_SAR,
        sbe_pkg::OP_SHR: q_item.kind = sbe_pkg::K_ALU;
        sbe_pkg::OP_END, sbe_pkg::OP_RETURN: q_item.kind = sbe_pkg::K_END;
        default: q_item.kind = sbe_pkg::K_UNKNOWN;
      endcase
    end else begin
      // operand bytes shift in from the top: little-endian
      acc_nxt   = {in_if.code_byte, acc_r[31:8]};
      phase_nxt = phase_r - 3'd1;
      q_item.opcode = pend_r;
      q_item.acc    = acc_nxt;
      if (phase_nxt == 3'd0) begin
        case (pend_r) inside
          sbe_pkg::OP_PUSH: q_item.kind = sbe_pkg::K_PUSH;
          sbe_pkg::OP_LOCAL_GET, sbe_pkg::OP_REG_LOAD: q_item.kind = sbe_pkg::K_GET;
          sbe_pkg::OP_LOCAL_SET, sbe_pkg::OP_REG_STORE: q_item.kind = sbe_pkg::K_SET;
          sbe_pkg::OP_MEM: q_item.kind = sbe_pkg::K_MEM;
          default: q_item.kind = sbe_pkg::K_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      pend_r  <= 8'd0;
      acc_r   <= 32'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sbe_queue.sv =====
// Two-entry queue of decoded work items between front and back end.
`default_nettype none
module sbe_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sbe_pkg::item_t  push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 valid,
  output sbe_pkg::item_t       head
);

  sbe_pkg::item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/sbe_back.sv =====
// Back end: operand stack, registers, RAM window and the result register.
`default_nettype none
module sbe_back #(
  parameter int STACK_DEPTH   = 1024,
  parameter int RAM_ADDR_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            q_valid,
  input  wire sbe_pkg::item_t  q_item,
  output logic                 q_pop,
  output logic                 clr_busy,
  sbe_result_if.source         out_if
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int RW   = RAM_ADDR_BITS - 2;
  localparam int ROWS = 2 ** RW;
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  sbe_pkg::bstate_t state_r, state_nxt;
  sbe_pkg::item_t   item_r;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [31:0]      tos_r, tos_nxt;
  logic [31:0]      regs_r [16];
  logic [31:0]      t_r;
  logic [7:0]       tag_r;
  logic             outside_r, outside_nxt;
  logic             clr_r;
  logic [RW-1:0]    clr_cnt_r;

  // stack memory: entries below the cached top of stack
  logic [31:0]      stk_mem [STACK_DEPTH];
  logic [31:0]      stk_rd_r;
  logic             stk_re, stk_we;
  logic [AW-1:0]    stk_raddr, stk_waddr;

  // RAM window: four byte banks, one per low address pair
  logic [7:0]       ram [4][ROWS];
  logic [7:0]       ram_rd_r [4];
  logic [31:0]      ram_addr;
  logic             ram_re, ram_wr_act;
  logic [RW-1:0]    ram_row [4];
  logic             ram_we [4];
  logic [7:0]       ram_wbyte [4];
  logic [31:0]      ram_wval;
  logic [7:0]       ram_size;

  // result register
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic             out_wr_r;
  logic [4:0]       out_idx_r;
  logic [31:0]      out_val_r;
  logic [SP_W-1:0]  out_depth_r;

  logic             fire, to_fill, commit;
  logic [2:0]       status;
  logic             wr;
  logic [4:0]       widx;
  logic [31:0]      wval;
  logic             reg_we, t_we;
  logic [31:0]      stk_wdata;

  assign clr_busy = clr_r;

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.reg_written = out_wr_r;
  assign out_if.reg_index   = out_idx_r;
  assign out_if.reg_value   = out_val_r;
  assign out_if.stack_depth = out_depth_r;

  // Sequencer and execution
  always_comb begin
    logic        ge1, ge2, ge3, under, over, outside, done, push_en, in_win, sized, mwr;
    logic [31:0] push_val, a, b, addr, rdval;
    logic [7:0]  idx;
    logic [1:0]  lo;
    ge1 = (sp_r != '0);
    ge2 = (sp_r > SP_W'(1));
    ge3 = (sp_r > SP_W'(2));
    under = 1'b0; over = 1'b0; outside = 1'b0; done = 1'b0; push_en = 1'b0;
    in_win = 1'b0; sized = 1'b0; mwr = 1'b0;
    push_val = 32'd0; a = 32'd0; b = 32'd0; addr = 32'd0; rdval = 32'd0;
    idx = item_r.acc[31:24];
    lo  = 2'd0;
    state_nxt   = state_r;
    sp_nxt      = sp_r;
    tos_nxt     = tos_r;
    outside_nxt = outside_r;
    q_pop     = 1'b0;
    stk_re    = 1'b0;
    stk_raddr = AW'(sp_r - SP_W'(2));
    stk_we    = 1'b0;
    stk_waddr = AW'(sp_r - SP_W'(1));
    stk_wdata = tos_r;
    ram_addr  = ge1 ? tos_r : 32'd0;
    ram_re    = 1'b0;
    ram_wr_act = 1'b0;
    ram_wval  = 32'd0;
    ram_size  = idx;
    wr = 1'b0; widx = 5'd0; wval = 32'd0; reg_we = 1'b0; t_we = 1'b0;
    status  = sbe_pkg::ST_OK;
    to_fill = 1'b0;
    fire    = 1'b0;
    case (state_r)
      sbe_pkg::B_IDLE: begin
        if (q_valid && !clr_r) begin
          q_pop     = 1'b1;
          stk_re    = 1'b1;
          ram_re    = 1'b1;
          state_nxt = sbe_pkg::B_EXEC;
        end
      end
      sbe_pkg::B_EXEC: begin
        sized = (idx == 8'd1) || (idx == 8'd2) || (idx == 8'd4);
        mwr   = (item_r.acc[23:16] != 8'd0);
        done  = 1'b1;
        case (item_r.kind)
          sbe_pkg::K_END:     status = sbe_pkg::ST_END;
          sbe_pkg::K_UNKNOWN: status = sbe_pkg::ST_UNKNOWN;
          sbe_pkg::K_PUSH: begin
            push_en  = 1'b1;
            push_val = item_r.acc;
          end
          sbe_pkg::K_GET: begin
            if (idx < sbe_pkg::T_FLAG_IDX) begin
              push_en  = 1'b1;
              push_val = regs_r[idx[3:0]];
            end else if (idx == sbe_pkg::T_FLAG_IDX) begin
              push_en  = 1'b1;
              push_val = t_r;
            end
          end
          sbe_pkg::K_SET: begin
            under = !ge1;
            if (ge1) begin
              sp_nxt  = sp_r - SP_W'(1);
              tos_nxt = stk_rd_r;
            end
            // index above the T flag pops and drops the value
            if (idx < sbe_pkg::T_FLAG_IDX) begin
              wr = 1'b1; widx = idx[4:0]; reg_we = 1'b1;
              wval = ge1 ? tos_r : 32'd0;
            end else if (idx == sbe_pkg::T_FLAG_IDX) begin
              wr = 1'b1; widx = idx[4:0]; t_we = 1'b1;
              wval = ge1 ? tos_r : 32'd0;
            end
          end
          sbe_pkg::K_ALU: begin
            under   = !ge2;
            b       = ge1 ? tos_r : 32'd0;
            a       = ge2 ? stk_rd_r : 32'd0;
            tos_nxt = sbe_pkg::alu(item_r.opcode, a, b);
            sp_nxt  = ge2 ? sp_r - SP_W'(1) : SP_W'(1);
          end
          sbe_pkg::K_MEM: begin
            if (!mwr) begin
              // read: pop address, push loaded value
              under  = !ge1;
              addr   = ge1 ? tos_r : 32'd0;
              in_win = (addr[31:24] == tag_r);
              outside = !in_win;
              lo = addr[1:0];
              for (int i = 0; i < 4; i++) begin
                if (8'(i) < idx) rdval[8*i +: 8] = ram_rd_r[2'(i) + lo];
              end
              tos_nxt = (in_win && sized) ? rdval : 32'd0;
              sp_nxt  = ge1 ? sp_r : SP_W'(1);
            end else begin
              // write: pop value, then address
              under    = !ge2;
              ram_wval = ge1 ? tos_r : 32'd0;
              addr     = ge2 ? stk_rd_r : 32'd0;
              ram_addr = addr;
              in_win   = (addr[31:24] == tag_r);
              outside  = !in_win;
              ram_wr_act = in_win && sized;
              if (ge3) begin
                done        = 1'b0;
                to_fill     = 1'b1;
                stk_re      = 1'b1;
                stk_raddr   = AW'(sp_r - SP_W'(3));
                outside_nxt = outside;
                state_nxt   = sbe_pkg::B_FILL;
              end else begin
                sp_nxt = '0;
              end
            end
          end
          default: ;
        endcase
        if (push_en) begin
          if (sp_r == SP_FULL) begin
            over = 1'b1;
          end else begin
            stk_we  = ge1;
            tos_nxt = push_val;
            sp_nxt  = sp_r + SP_W'(1);
          end
        end
        if (status == sbe_pkg::ST_OK) begin
          if (under) status = sbe_pkg::ST_UNDER;
          else if (over) status = sbe_pkg::ST_OVER;
          else if (outside) status = sbe_pkg::ST_OUTSIDE;
        end
        fire = done && (!out_valid_r || out_if.ready);
        if (fire) state_nxt = sbe_pkg::B_IDLE;
        if (!fire && !to_fill) ram_wr_act = 1'b0;
      end
      sbe_pkg::B_FILL: begin
        tos_nxt = stk_rd_r;
        sp_nxt  = sp_r - SP_W'(2);
        status  = outside_r ? sbe_pkg::ST_OUTSIDE : sbe_pkg::ST_OK;
        fire    = !out_valid_r || out_if.ready;
        if (fire) state_nxt = sbe_pkg::B_IDLE;
      end
      default: state_nxt = sbe_pkg::B_IDLE;
    endcase
    stk_we = stk_we && fire;
    commit = fire;
  end

  // RAM bank addressing: byte i of an access lands in bank (addr + i) mod 4
  always_comb begin
    logic [RAM_ADDR_BITS-1:0] off, sum;
    logic [1:0]               ik;
    off = ram_addr[RAM_ADDR_BITS-1:0];
    for (int k = 0; k < 4; k++) begin
      ik  = 2'(k) - off[1:0];
      sum = off + RAM_ADDR_BITS'(ik);
      ram_row[k]   = clr_r ? clr_cnt_r : sum[RAM_ADDR_BITS-1:2];
      ram_wbyte[k] = clr_r ? 8'd0 : ram_wval[8*ik +: 8];
      ram_we[k]    = clr_r || (ram_wr_act && ({6'd0, ik} < ram_size));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (ram_we[k]) ram[k][ram_row[k]] <= ram_wbyte[k];
      if (ram_re) ram_rd_r[k] <= ram[k][ram_row[k]];
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

  // Item latch and cached top of stack
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (commit) tos_r <= tos_nxt;
    outside_r <= outside_nxt;
  end

  // Control state, registers and RAM clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sbe_pkg::B_IDLE;
      sp_r      <= '0;
      t_r       <= 32'd0;
      tag_r     <= sbe_pkg::WIN_TAG_RST;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      for (int r = 0; r < 16; r++) regs_r[r] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (commit) sp_r <= sp_nxt;
      if (cfg_we) tag_r <= cfg_wdata;
      if (fire && reg_we) regs_r[widx[3:0]] <= wval;
      if (fire && t_we) t_r <= wval;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + RW'(1);
        if (clr_cnt_r == RW'(ROWS - 1)) clr_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status;
      out_wr_r     <= wr;
      out_idx_r    <= widx;
      out_val_r    <= wval;
      out_depth_r  <= sp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/stack_bytecode_executor_core.sv =====
// Top level of the stack bytecode executor.
`default_nettype none
`include "assert_macros.svh"
// Takes one bytecode byte per request and returns one result per byte. A byte
// that needs no stack memory read (operand bytes, pushes, END, unknown codes,
// memory reads) passes the back end's idle and execute states; ALU ops and
// register stores do the same, each using one read of the stack memory port;
// a memory write with three or more stack entries also passes the fill state
// because it needs two reads of that single port. A two-entry queue lets the
// decoder keep taking bytes while execution or the result side stalls. After
// reset the local RAM is zeroed one row of four bytes per cycle, all rows
// (2**(RAM_ADDR_BITS-2), 16384 at the default), during which no byte is taken;
// the window tag register may be written at any time while the block is idle.
module stack_bytecode_executor_core #(
  parameter int STACK_DEPTH   = 1024,
  parameter int RAM_ADDR_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  sbe_code_if.sink        in_if,
  sbe_result_if.source    out_if
);

  logic           q_push, q_pop, q_full, q_valid, clr_busy;
  sbe_pkg::item_t q_in, q_head;

  sbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  sbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  sbe_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_if    (out_if)
  );

  // Checks
  `SBE_CHECK(a_no_push_when_full, !(q_push && q_full), "queue written while full")
  `SBE_CHECK(a_no_take_while_clr, clr_busy |-> !in_if.ready, "byte taken during RAM clear")
  `SBE_CHECK_NEXT(a_push_lands, q_push, q_valid, "queued item missing")
  `SBE_CHECK(a_depth_range, out_if.valid |-> (out_if.stack_depth <= STACK_DEPTH), "depth too big")

endmodule
`default_nettype wire

// ===== dv/sbe_result_checker.sv =====
// Checker for the bytecode executor: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module sbe_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  sbe_code_if        code_mon,
  sbe_result_if      res_mon,
  output int         errors,
  output int         pending
);

  localparam int STK_SIZE = 1024;
  localparam int RAM_SIZE = 65536;

  typedef struct packed {
    logic [2:0]  status;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [10:0] stack_depth;
  } exec_result_t;

  // Shadow of the executor state
  logic [31:0] stk [STK_SIZE];
  int unsigned sp;
  logic [31:0] regs [16];
  logic [31:0] t_val;
  int unsigned phase;
  logic [7:0]  pend_op;
  logic [31:0] acc;
  logic [7:0]  ram [RAM_SIZE];
  logic [7:0]  win_tag;
  bit          f_under, f_over, f_outside;

  exec_result_t result_q[$];

  function automatic logic [31:0] stk_pop();
    if (sp == 0) begin
      f_under = 1'b1;
      return 32'd0;
    end
    sp--;
    return stk[sp];
  endfunction

  function automatic void stk_push(input logic [31:0] v);
    if (sp >= STK_SIZE) begin
      f_over = 1'b1;
      return;
    end
    stk[sp] = v;
    sp++;
  endfunction

  function automatic logic [31:0] alu_result(input logic [7:0] op, input logic [31:0] a,
                                             input logic [31:0] b);
    logic [4:0] s;
    s = b[4:0];
    case (op)
      sbe_pkg::OP_ADD: return a + b;
      sbe_pkg::OP_SUB: return a - b;
      sbe_pkg::OP_AND: return a & b;
      sbe_pkg::OP_OR:  return a | b;
      sbe_pkg::OP_XOR: return a ^ b;
      sbe_pkg::OP_SHL: return a << s;
      sbe_pkg::OP_SHR: return a >> s;
      default: return (a >> s) | (a[31] ? ~(32'hFFFF_FFFF >> s) : 32'd0);
    endcase
  endfunction

  // Load or store through the RAM window
  function automatic void ram_access(input logic [7:0] op_type, input logic [7:0] size);
    logic [31:0] addr, val;
    logic [15:0] off;
    bit sized;
    val = 32'd0;
    sized = (size == 8'd1 || size == 8'd2 || size == 8'd4);
    if (op_type == 8'd0) begin
      addr = stk_pop();
      if (addr[31:24] != win_tag) begin
        f_outside = 1'b1;
      end else if (sized) begin
        off = addr[15:0];
        for (int i = 0; i < size; i++) val[8*i +: 8] = ram[16'(off + i)];
      end
      stk_push(val);
    end else begin
      val = stk_pop();
      addr = stk_pop();
      if (addr[31:24] != win_tag) begin
        f_outside = 1'b1;
      end else if (sized) begin
        off = addr[15:0];
        for (int i = 0; i < size; i++) ram[16'(off + i)] = val[8*i +: 8];
      end
    end
  endfunction

  // One code byte through the decoder and executor
  function automatic exec_result_t exec_byte(input logic [7:0] b);
    exec_result_t r;
    logic [31:0] x, y, v;
    logic [7:0] idx;
    r = '0;
    f_under = 0;
    f_over = 0;
    f_outside = 0;
    if (phase == 0) begin
      pend_op = b;
      acc = 32'd0;
      case (b) inside
        sbe_pkg::OP_PUSH: phase = 4;
        sbe_pkg::OP_LOCAL_GET, sbe_pkg::OP_LOCAL_SET, sbe_pkg::OP_REG_LOAD,
        sbe_pkg::OP_REG_STORE: phase = 1;
        sbe_pkg::OP_MEM: phase = 2;
        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_AND, sbe_pkg::OP_OR, sbe_pkg::OP_XOR,
        sbe_pkg::OP_SHL, sbe_pkg::OP_SAR, sbe_pkg::OP_SHR: begin
          y = stk_pop();
          x = stk_pop();
          stk_push(alu_result(b, x, y));
        end
        sbe_pkg::OP_END, sbe_pkg::OP_RETURN: r.status = sbe_pkg::ST_END;
        default: r.status = sbe_pkg::ST_UNKNOWN;
      endcase
    end else begin
      acc = {b, acc[31:8]};
      phase--;
      if (phase == 0) begin
        idx = acc[31:24];
        case (pend_op) inside
          sbe_pkg::OP_PUSH: stk_push(acc);
          sbe_pkg::OP_LOCAL_GET, sbe_pkg::OP_REG_LOAD: begin
            if (idx < 16) stk_push(regs[idx[3:0]]);
            else if (idx == sbe_pkg::T_FLAG_IDX) stk_push(t_val);
          end
          sbe_pkg::OP_LOCAL_SET, sbe_pkg::OP_REG_STORE: begin
            v = stk_pop();
            if (idx < 16) begin
              regs[idx[3:0]] = v;
              r.reg_written = 1'b1;
              r.reg_index = idx[4:0];
              r.reg_value = v;
            end else if (idx == sbe_pkg::T_FLAG_IDX) begin
              t_val = v;
              r.reg_written = 1'b1;
              r.reg_index = 5'd16;
              r.reg_value = v;
            end
          end
          sbe_pkg::OP_MEM: ram_access(acc[23:16], idx);
          default: ;
        endcase
      end
    end
    // Fault priority: underflow, then overflow, then outside window
    if (r.status == sbe_pkg::ST_OK) begin
      if (f_under) r.status = sbe_pkg::ST_UNDER;
      else if (f_over) r.status = sbe_pkg::ST_OVER;
      else if (f_outside) r.status = sbe_pkg::ST_OUTSIDE;
    end
    r.stack_depth = 11'(sp);
    return r;
  endfunction

  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst_n) begin
      sp = 0;
      phase = 0;
      pend_op = 8'd0;
      acc = 32'd0;
      t_val = 32'd0;
      win_tag = sbe_pkg::WIN_TAG_RST;
      foreach (regs[i]) regs[i] = 32'd0;
      foreach (ram[i]) ram[i] = 8'd0;
      result_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) win_tag = cfg_wdata;
      // Requests first, so a same-edge result still finds its prediction
      if (code_mon.valid && code_mon.ready)
        result_q.insert(result_q.size(), exec_byte(code_mon.code_byte));
      if (res_mon.valid && res_mon.ready) begin
        got.status = res_mon.status;
        got.reg_written = res_mon.reg_written;
        got.reg_index = res_mon.reg_index;
        got.reg_value = res_mon.reg_value;
        got.stack_depth = res_mon.stack_depth;
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected result: status %0d depth %0d", got.status,
                                    got.stack_depth);
          errors <= errors + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("mismatch: exp st=%0d wr=%0d idx=%0d val=%h dep=%0d",
                       want.status, want.reg_written, want.reg_index, want.reg_value,
                       want.stack_depth);
              $display("          got st=%0d wr=%0d idx=%0d val=%h dep=%0d",
                       got.status, got.reg_written, got.reg_index, got.reg_value,
                       got.stack_depth);
            end
            errors <= errors + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule

// ===== dv/tb_stack_bytecode_executor_core.sv =====
// Testbench top: clock, reset, bytecode stimulus, window tag writes and the verdict.
`timescale 1ns / 1ps
module tb_stack_bytecode_executor_core;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         errors;
  int         pending;
  int         bytes_sent;
  bit         steady;
  logic [7:0] cur_tag;

  sbe_code_if code_ch ();
  sbe_result_if #(.DEPTH_W(11)) res_ch ();

  stack_bytecode_executor_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (code_ch),
    .out_if    (res_ch)
  );

  sbe_result_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .code_mon  (code_ch),
    .res_mon   (res_ch),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: covers the RAM clear after reset and the stack fill pass
  initial begin
    #10ms;
    $display("tb_stack_bytecode_executor_core: errors");
    $finish;
  end

  // Result side back-pressure
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // One code byte request; ready is sampled mid-cycle to stay clear of the edge
  task automatic send_byte(input logic [7:0] b);
    logic rdy;
    if (!steady && $urandom_range(99) < 25) begin
      code_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    code_ch.valid <= 1'b1;
    code_ch.code_byte <= b;
    forever begin
      @(negedge clk);
      rdy = code_ch.ready;
      @(posedge clk);
      if (rdy) break;
    end
    bytes_sent++;
  endtask

  task automatic send_push(input logic [31:0] v);
    send_byte(sbe_pkg::OP_PUSH);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic drain();
    code_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tag(input logic [7:0] t);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_tag = t;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) != 0) a[31:24] = cur_tag;
    case ($urandom_range(9)) inside
      0: a[15:0] = 16'hFFFC + 16'($urandom_range(3));
      [1:2]: a[15:0] = 16'($urandom);
      default: a[15:0] = 16'($urandom_range(63));
    endcase
    return a;
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(9)) inside
      [0:2]: return 8'd1;
      [3:4]: return 8'd2;
      [5:6]: return 8'd4;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'($urandom_range(16));
  endfunction

  function automatic bit is_opcode(input logic [7:0] b);
    case (b) inside
      sbe_pkg::OP_PUSH, sbe_pkg::OP_LOCAL_GET, sbe_pkg::OP_LOCAL_SET, sbe_pkg::OP_REG_LOAD,
      sbe_pkg::OP_REG_STORE, sbe_pkg::OP_MEM, sbe_pkg::OP_ADD, sbe_pkg::OP_SUB,
      sbe_pkg::OP_AND, sbe_pkg::OP_OR, sbe_pkg::OP_XOR, sbe_pkg::OP_SHL, sbe_pkg::OP_SAR,
      sbe_pkg::OP_SHR, sbe_pkg::OP_END, sbe_pkg::OP_RETURN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // One random instruction sequence, mostly well formed
  task automatic send_random_seq();
    logic [7:0] alu_ops [8];
    logic [7:0] b;
    int sel;
    alu_ops = '{sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_AND, sbe_pkg::OP_OR,
                sbe_pkg::OP_XOR, sbe_pkg::OP_SHL, sbe_pkg::OP_SAR, sbe_pkg::OP_SHR};
    sel = $urandom_range(99);
    if (sel < 18) begin
      send_push(pick_value());
    end else if (sel < 28) begin
      send_byte($urandom_range(1) ? sbe_pkg::OP_LOCAL_GET : sbe_pkg::OP_REG_LOAD);
      send_byte(pick_index());
    end else if (sel < 38) begin
      send_byte($urandom_range(1) ? sbe_pkg::OP_LOCAL_SET : sbe_pkg::OP_REG_STORE);
      send_byte(pick_index());
    end else if (sel < 56) begin
      if ($urandom_range(1)) send_push(pick_value());
      send_byte(alu_ops[$urandom_range(7)]);
    end else if (sel < 68) begin
      send_push(pick_addr());
      send_push(pick_value());
      send_byte(sbe_pkg::OP_MEM);
      send_byte(8'($urandom_range(1, 255)));
      send_byte(pick_size());
    end else if (sel < 78) begin
      send_push(pick_addr());
      send_byte(sbe_pkg::OP_MEM);
      send_byte(8'd0);
      send_byte(pick_size());
    end else if (sel < 84) begin
      send_byte($urandom_range(1) ? sbe_pkg::OP_END : sbe_pkg::OP_RETURN);
    end else if (sel < 90) begin
      do b = 8'($urandom); while (is_opcode(b));
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] tags [4];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'd0;
    code_ch.valid <= 1'b0;
    code_ch.code_byte <= 8'd0;
    steady = 0;
    bytes_sent = 0;
    cur_tag = sbe_pkg::WIN_TAG_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unknown codes, block ends, underflow, T flag and high indexes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sbe_pkg::OP_END);
    send_byte(sbe_pkg::OP_RETURN);
    send_byte(sbe_pkg::OP_ADD);
    send_byte(sbe_pkg::OP_LOCAL_SET);
    send_byte(sbe_pkg::T_FLAG_IDX);
    send_push(32'hFFFF_FFFF);
    send_byte(sbe_pkg::OP_LOCAL_SET);
    send_byte(sbe_pkg::T_FLAG_IDX);
    send_byte(sbe_pkg::OP_LOCAL_GET);
    send_byte(sbe_pkg::T_FLAG_IDX);
    send_byte(sbe_pkg::OP_REG_LOAD);
    send_byte(8'd200);
    send_byte(sbe_pkg::OP_REG_STORE);
    send_byte(8'd15);

    // Random phases, each after a window tag write (0, 255, the reset tag, random)
    tags = '{8'd0, 8'd255, sbe_pkg::WIN_TAG_RST, 8'($urandom)};
    for (int p = 0; p < 4; p++) begin
      drain();
      write_tag(tags[p]);
      steady = (p == 1);
      repeat (65) send_random_seq();
      if (p == 2) begin
        // Build a deep stack, then fold it back down
        for (int i = 0; i < 150; i++) begin
          send_byte(sbe_pkg::OP_REG_LOAD);
          send_byte(8'($urandom_range(16)));
        end
        repeat (150) send_byte(sbe_pkg::OP_XOR);
      end
    end
    steady = 0;
    drain();
    if (errors == 0) begin
      $display("tb_stack_bytecode_executor_core: clean");
    end else begin
      $display("tb_stack_bytecode_executor_core: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/sbe_pkg.sv
src/sbe_ifaces.sv
src/sbe_front.sv
src/sbe_queue.sv
src/sbe_back.sv
src/stack_bytecode_executor_core.sv
dv/sbe_result_checker.sv
dv/tb_stack_bytecode_executor_core.sv
